// ===== design/srss_pkg.sv =====
`default_nettype none

package srss_pkg;

  // default build figures
  localparam int MAX_RECTS_DEF  = 256;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths of the stream items
  localparam int FIELD_W   = 16;
  localparam int SLOT_W    = 8;
  localparam int ID_W      = 8;
  localparam int COUNT_W   = 9;
  localparam int CHOSEN_W  = 9;
  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 16;

  // item kinds carried in s_tuser
  localparam logic [0:0] ACT_LOAD  = 1'b0;
  localparam logic [0:0] ACT_QUERY = 1'b1;

  // fitness tiers, higher is better
  localparam logic [1:0] TIER_NARROW = 2'd0;
  localparam logic [1:0] TIER_ONE    = 2'd1;
  localparam logic [1:0] TIER_TWO    = 2'd2;
  localparam logic [1:0] TIER_FULL   = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // verdict on one candidate rectangle
  typedef struct packed {
    logic       fits;
    logic [1:0] tier;
    logic       left;
  } cand_t;

endpackage

`default_nettype wire

// ===== design/srss_score.sv =====
`default_nettype none

module srss_score #(
  parameter int COORD_BITS = srss_pkg::COORD_BITS_DEF
) (
  input  wire logic signed [COORD_BITS+1:0] gap_w,
  input  wire logic signed [COORD_BITS:0]   gap_lr,
  input  wire logic signed [COORD_BITS:0]   gap_rr,
  input  wire logic        [COORD_BITS-1:0] rect_w,
  input  wire logic        [COORD_BITS-1:0] rect_h,
  output srss_pkg::cand_t                   cand
);
  import srss_pkg::*;

  logic signed [COORD_BITS+1:0] w_ext;
  logic signed [COORD_BITS:0]   h_ext;
  logic                         fill;
  logic                         ml;
  logic                         mr;

  assign w_ext = $signed({2'b00, rect_w});
  assign h_ext = $signed({1'b0, rect_h});
  assign fill  = (gap_w == w_ext);
  assign ml    = (gap_lr == h_ext);
  assign mr    = (gap_rr == h_ext);

  // tier and side; right wall wins the one-sided tier, left wall the two-sided
  always_comb begin
    cand.fits = (gap_w >= w_ext);
    if (fill && ml && mr) begin
      cand.tier = TIER_FULL;
      cand.left = 1'b1;
    end else if (fill && (ml || mr)) begin
      cand.tier = TIER_TWO;
      cand.left = ml;
    end else if (fill || ml || mr) begin
      cand.tier = TIER_ONE;
      cand.left = !mr;
    end else begin
      cand.tier = TIER_NARROW;
      cand.left = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/skyline_rect_score_select_top.sv =====
`default_nettype none

// Load item: written into the table in the cycle it is accepted, no result.
// Query item: with n = min(rect_count, MAX_RECTS), the first n slots are scanned, and
// the result goes to the m_tdata register once the output is free; no next item is
// taken before that. The scan reads one table slot a cycle through the single read
// port of each memory. Reset: a clearing pass wipes the used marks, no item is taken
// meanwhile; configuration writes are taken at all times.
module skyline_rect_score_select_top #(
  parameter int MAX_RECTS  = srss_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = srss_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // cfg_data: rect_count
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srss_pkg::COUNT_W-1:0]   cfg_data,
  // s_tdata: slot, rect_ident, rect_width, rect_height, seg_left, seg_right,
  //          seg_floor, seg_left_wall, seg_right_wall
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [srss_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: action
  input  wire logic [0:0]                     s_tuser,
  // m_tdata: chosen_id, place_left, found, all_used, zero fill
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [srss_pkg::M_TDATA_W-1:0]      m_tdata
);
  import srss_pkg::*;

  localparam int IDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW     = $clog2(MAX_RECTS + 1);
  localparam int SW     = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int GW     = COORD_BITS + 2;
  localparam int ENT_W  = ID_W + 2 * COORD_BITS;

  function automatic logic [COORD_BITS-1:0] coord(input logic [FIELD_W-1:0] f);
    logic [FIELD_W+COORD_BITS-1:0] wide;
    wide = {{COORD_BITS{1'b0}}, f};
    return wide[COORD_BITS-1:0];
  endfunction

  // input fields
  logic [SLOT_W-1:0]  in_slot;
  logic [ID_W-1:0]    in_ident;
  logic [FIELD_W-1:0] in_width;
  logic [FIELD_W-1:0] in_height;
  logic [FIELD_W-1:0] in_left;
  logic [FIELD_W-1:0] in_right;
  logic [FIELD_W-1:0] in_floor;
  logic [FIELD_W-1:0] in_lwall;
  logic [FIELD_W-1:0] in_rwall;

  assign in_slot   = s_tdata[7:0];
  assign in_ident  = s_tdata[15:8];
  assign in_width  = s_tdata[31:16];
  assign in_height = s_tdata[47:32];
  assign in_left   = s_tdata[63:48];
  assign in_right  = s_tdata[79:64];
  assign in_floor  = s_tdata[95:80];
  assign in_lwall  = s_tdata[111:96];
  assign in_rwall  = s_tdata[127:112];

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0] rect_count;
  logic [SW-1:0]      cnt;
  logic [SW-1:0]      scan_len;
  logic [SW-1:0]      scan_len_next;
  logic [SW-1:0]      count_ext;
  logic [SW-1:0]      slot_ext;
  logic [IDX_W-1:0]   load_addr;
  logic               load_in_range;

  logic signed [GW-1:0]         gap_w;
  logic signed [COORD_BITS:0]   gap_lr;
  logic signed [COORD_BITS:0]   gap_rr;
  logic signed [GW-1:0]         gap_w_next;
  logic signed [COORD_BITS:0]   gap_lr_next;
  logic signed [COORD_BITS:0]   gap_rr_next;

  // memories
  logic [ENT_W-1:0] tab_mem [MAX_RECTS];
  logic             used_mem [MAX_RECTS];
  logic [ENT_W-1:0] tab_rd;
  logic             used_rd;
  logic             tab_we;
  logic             used_we;
  logic             used_wd;
  logic [IDX_W-1:0] used_addr;
  logic [IDX_W-1:0] rd_addr;

  // scan control and best-so-far
  logic             issuing;
  logic             eval_valid;
  logic [IDX_W-1:0] eval_idx;
  logic             scan_any;
  logic             best_have;
  logic [1:0]       best_tier;
  logic             best_left;
  logic [IDX_W-1:0] best_slot;
  logic [ID_W-1:0]  best_id;
  cand_t            cand;

  logic                out_free;
  logic                out_load;
  logic                query_acc;
  logic [CHOSEN_W-1:0] res_id;
  logic                res_left;

  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count <= '0;
    end else if (cfg_valid) begin
      rect_count <= cfg_data;
    end
  end

  assign count_ext     = SW'(rect_count);
  assign scan_len_next = (count_ext > SW'(MAX_RECTS)) ? SW'(MAX_RECTS) : count_ext;
  assign slot_ext      = SW'(in_slot);
  assign load_addr     = slot_ext[IDX_W-1:0];
  assign load_in_range = (slot_ext < SW'(MAX_RECTS));
  assign rd_addr       = cnt[IDX_W-1:0];
  assign out_free      = !m_tvalid || m_tready;
  assign query_acc     = s_tvalid && s_tready && (s_tuser == ACT_QUERY);

  // gap geometry as signed differences
  assign gap_w_next  = $signed({2'b00, coord(in_right)}) - $signed({2'b00, coord(in_left)})
                       + $signed(GW'(1));
  assign gap_lr_next = $signed({1'b0, coord(in_lwall)}) - $signed({1'b0, coord(in_floor)});
  assign gap_rr_next = $signed({1'b0, coord(in_rwall)}) - $signed({1'b0, coord(in_floor)});

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    issuing    = 1'b0;
    out_load   = 1'b0;
    tab_we     = 1'b0;
    used_we    = 1'b0;
    used_wd    = 1'b0;
    used_addr  = cnt[IDX_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        used_we = 1'b1;
        if (cnt == SW'(MAX_RECTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == ACT_QUERY) begin
            state_next = ST_SCAN;
          end else if (load_in_range) begin
            tab_we    = 1'b1;
            used_we   = 1'b1;
            used_addr = load_addr;
          end
        end
      end
      ST_SCAN: begin
        issuing = (cnt < scan_len);
        if (!issuing && !eval_valid) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          if (best_have) begin
            used_we   = 1'b1;
            used_addr = best_slot;
            used_wd   = 1'b1;
          end
        end
      end
    endcase
  end

  // slot counter: clearing sweep, then scan address
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= issuing;
      if (query_acc) begin
        cnt <= '0;
      end else if (state == ST_CLEAR || issuing) begin
        cnt <= cnt + SW'(1);
      end
    end
  end

  // table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[load_addr] <= {in_ident, coord(in_width), coord(in_height)};
    if (issuing) tab_rd <= tab_mem[rd_addr];
  end

  // used-mark memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_addr] <= used_wd;
    if (issuing) used_rd <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (issuing) eval_idx <= rd_addr;
  end

  // gap registers captured with the query
  always_ff @(posedge clk) begin
    if (query_acc) begin
      gap_w    <= gap_w_next;
      gap_lr   <= gap_lr_next;
      gap_rr   <= gap_rr_next;
      scan_len <= scan_len_next;
    end
  end

  srss_score #(
    .COORD_BITS(COORD_BITS)
  ) u_score (
    .gap_w  (gap_w),
    .gap_lr (gap_lr),
    .gap_rr (gap_rr),
    .rect_w (tab_rd[2*COORD_BITS-1:COORD_BITS]),
    .rect_h (tab_rd[COORD_BITS-1:0]),
    .cand   (cand)
  );

  // best-so-far; a later slot wins only with a strictly higher tier
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_any  <= 1'b0;
      best_have <= 1'b0;
    end else if (query_acc) begin
      scan_any  <= 1'b0;
      best_have <= 1'b0;
    end else if (eval_valid && !used_rd) begin
      scan_any <= 1'b1;
      if (cand.fits && (!best_have || (cand.tier > best_tier))) begin
        best_have <= 1'b1;
        best_tier <= cand.tier;
        best_left <= cand.left;
        best_slot <= eval_idx;
        best_id   <= tab_rd[ENT_W-1:2*COORD_BITS];
      end
    end
  end

  // result fields: chosen, nothing fits, or finished
  always_comb begin
    if (!scan_any) begin
      res_id   = '0;
      res_left = 1'b0;
    end else if (best_have) begin
      res_id   = {1'b0, best_id};
      res_left = best_left;
    end else begin
      res_id   = '1;
      res_left = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0000, !scan_any, best_have, res_left, res_id};
    end
  end

  // checks
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish step");

  a_found_excl_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
    else $error("found and all_used both set");

  a_winner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && best_have) |-> (SW'(best_slot) < scan_len))
    else $error("winning slot beyond scanned range");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> state == ST_SCAN)
    else $error("table data evaluated outside scan");

endmodule

`default_nettype wire

// ===== tb/sv/skyline_rect_score_select_top_tb.sv =====
module skyline_rect_score_select_top_tb;
  import srss_pkg::*;

  localparam int SLOTS         = MAX_RECTS_DEF;
  localparam int NO_TIER       = -1;
  localparam int T_NARROW      = int'(TIER_NARROW);
  localparam int T_ONE         = int'(TIER_ONE);
  localparam int T_TWO         = int'(TIER_TWO);
  localparam int T_FULL        = int'(TIER_FULL);
  localparam int PHASE_ITEMS   = 170;
  localparam int SQUEEZE_PHASE = 4;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = MAX_RECTS_DEF + 16;
  localparam longint RUN_LIMIT = 40_000_000;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [15:0] rwall;
    logic [15:0] lwall;
    logic [15:0] floor_h;
    logic [15:0] right;
    logic [15:0] left;
    logic [15:0] rheight;
    logic [15:0] rwidth;
    logic [7:0]  ident;
    logic [7:0]  slot;
  } stream_word_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0] pad;
    logic       all_used;
    logic       found;
    logic       place_left;
    logic [8:0] chosen;
  } result_word_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT} rx_mode_t;

  // rectangle table mirror plus the queue of placements still owed
  class pick_ledger;
    logic [7:0]   ids [SLOTS];
    logic [15:0]  widths [SLOTS];
    logic [15:0]  heights [SLOTS];
    bit           used [SLOTS];
    int           rect_count;
    result_word_t due_picks [$];
    int           errors, loads, queries, placed, finished, misses, checked;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // best-fit choice for one gap, marks the winner used
    function result_word_t choose(stream_word_t g);
      int gap_w, rise_l, rise_r, rwid, rhgt, n, best, win, i;
      bit any_free, fill, ml, mr, go_left;
      result_word_t r;
      gap_w  = int'(g.right) - int'(g.left) + 1;
      rise_l = int'(g.lwall) - int'(g.floor_h);
      rise_r = int'(g.rwall) - int'(g.floor_h);
      n = (rect_count > SLOTS) ? SLOTS : rect_count;
      best = NO_TIER;
      win = 0;
      go_left = 1'b1;
      any_free = 1'b0;
      for (i = 0; i < n; i++) begin
        if (used[i]) continue;
        any_free = 1'b1;
        rwid = int'(widths[i]);
        rhgt = int'(heights[i]);
        if (gap_w < rwid) continue;
        fill = (gap_w == rwid);
        ml = (rise_l == rhgt);
        mr = (rise_r == rhgt);
        if (best < T_FULL && fill && ml && mr) begin
          best = T_FULL; win = i; go_left = 1'b1;
        end
        if (best < T_TWO && fill) begin
          if (ml) begin
            best = T_TWO; win = i; go_left = 1'b1;
          end else if (mr) begin
            best = T_TWO; win = i; go_left = 1'b0;
          end
        end
        if (best < T_ONE) begin
          if (fill || ml) begin
            best = T_ONE; win = i; go_left = 1'b1;
          end
          // right wall match wins the side
          if (mr) begin
            best = T_ONE; win = i; go_left = 1'b0;
          end
        end
        if (best < T_NARROW && rwid < gap_w) begin
          best = T_NARROW; win = i; go_left = 1'b1;
        end
      end
      r = '0;
      if (!any_free) begin
        r.all_used = 1'b1;
        finished++;
      end else if (best != NO_TIER) begin
        used[win] = 1'b1;
        r.chosen = {1'b0, ids[win]};
        r.place_left = go_left;
        r.found = 1'b1;
        placed++;
      end else begin
        r.chosen = '1;
        r.place_left = 1'b1;
        misses++;
      end
      return r;
    endfunction

    function void take_item(logic [0:0] act, stream_word_t w);
      if (act == ACT_LOAD) begin
        ids[w.slot] = w.ident;
        widths[w.slot] = w.rwidth;
        heights[w.slot] = w.rheight;
        used[w.slot] = 1'b0;
        loads++;
      end else begin
        due_picks.push_back(choose(w));
        queries++;
      end
    endfunction

    task match_pick(result_word_t got);
      result_word_t want;
      checked++;
      if (due_picks.size() == 0) begin
        report($sformatf("result %h with no query pending", got));
        return;
      end
      want = due_picks.pop_front();
      if (got.chosen !== want.chosen)
        report($sformatf("chosen_id got %h want %h", got.chosen, want.chosen));
      if (got.place_left !== want.place_left)
        report($sformatf("place_left got %b want %b", got.place_left, want.place_left));
      if (got.found !== want.found)
        report($sformatf("found got %b want %b", got.found, want.found));
      if (got.all_used !== want.all_used)
        report($sformatf("all_used got %b want %b", got.all_used, want.all_used));
      if (got.pad !== want.pad)
        report($sformatf("fill bits got %h want %h", got.pad, want.pad));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [0:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  pick_ledger ledger;
  bit         ever_loaded [SLOTS];
  bit         squeeze_req;

  skyline_rect_score_select_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one item and hold it until taken
  task automatic push_item(logic [0:0] act, stream_word_t w);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = w;
    do @(posedge clk); while (!s_tready);
    if (act == ACT_LOAD) ever_loaded[w.slot] = 1'b1;
    ledger.take_item(act, w);
  endtask

  task automatic sender_gap(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
  endtask

  task automatic write_count(int v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    ledger.rect_count = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every owed placement, then let the design settle
  task automatic drain();
    sender_gap(1);
    while (ledger.due_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_slot(int s, logic [7:0] id, logic [15:0] wd, logic [15:0] ht);
    stream_word_t w;
    w = {$urandom, $urandom, $urandom, $urandom};
    w.slot = s[7:0];
    w.ident = id;
    w.rwidth = wd;
    w.rheight = ht;
    push_item(ACT_LOAD, w);
  endtask

  task automatic query_gap(logic [15:0] l, logic [15:0] r, logic [15:0] f,
                           logic [15:0] lw, logic [15:0] rw);
    stream_word_t w;
    w = {$urandom, $urandom, $urandom, $urandom};
    w.left = l;
    w.right = r;
    w.floor_h = f;
    w.lwall = lw;
    w.rwall = rw;
    push_item(ACT_QUERY, w);
  endtask

  // mostly small shapes so widths and wall rises line up
  function automatic logic [15:0] rect_dim(int lo);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(lo, 6));
  endfunction

  function automatic logic [15:0] wall_over(logic [15:0] f);
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return f + 16'($urandom_range(0, 6));
  endfunction

  task automatic random_item(int n);
    stream_word_t w;
    int sel, gw, s;
    logic [15:0] l, f;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // raw noise: reversed gaps, walls under the floor, any slot
      w = {$urandom, $urandom, $urandom, $urandom};
      push_item(1'($urandom_range(0, 1)), w);
    end else if (sel < 45) begin
      if (n > 0 && $urandom_range(0, 4) != 0) s = $urandom_range(0, n - 1);
      else s = $urandom_range(0, SLOTS - 1);
      load_slot(s, 8'($urandom_range(0, 255)), rect_dim(1), rect_dim(0));
    end else begin
      gw = $urandom_range(1, 6);
      l = 16'($urandom_range(0, 65536 - gw));
      f = 16'($urandom_range(0, 65000));
      query_gap(l, l + 16'(gw - 1), f, wall_over(f), wall_over(f));
    end
  endtask

  // result side: checks at the rising edge, stalls on its own pattern
  initial begin : result_sink
    rx_mode_t mode;
    int mode_left, hold_left;
    bit squeezed;
    result_word_t got;
    m_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        ledger.match_pick(got);
      end
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        case (mode)
          RX_OPEN: m_tready = 1'b1;
          RX_COIN: m_tready = 1'($urandom_range(0, 1));
          default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("skyline_rect_score_select_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int sizes [11];
    int p, k, s, n, burst_left;
    ledger = new();
    sizes = '{256, 1, 0, 7, 16, 2, 33, 4, 255, 9, 130};
    burst_left = 0;
    squeeze_req = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_LOAD;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, each tier, both sides, misses and edges
    query_gap(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    drain();
    write_count(4);
    load_slot(0, 8'hFF, 16'd5, 16'd3);
    load_slot(1, 8'h00, 16'd5, 16'd3);
    load_slot(2, 8'h07, 16'd2, 16'd0);
    load_slot(3, 8'h80, 16'hFFFF, 16'hFFFF);
    query_gap(16'd10, 16'd14, 16'd100, 16'd103, 16'd103);
    query_gap(16'd10, 16'd14, 16'd100, 16'd103, 16'd103);
    query_gap(16'd10, 16'd14, 16'd100, 16'd103, 16'd50);
    query_gap(16'd10, 16'd14, 16'd100, 16'd103, 16'd103);
    query_gap(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    query_gap(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    load_slot(0, 8'h01, 16'd4, 16'd2);
    load_slot(1, 8'h02, 16'd4, 16'd6);
    load_slot(2, 8'h03, 16'd3, 16'd6);
    load_slot(3, 8'h04, 16'd4, 16'd6);
    query_gap(16'd100, 16'd50, 16'd10, 16'd16, 16'd16);
    query_gap(16'd20, 16'd23, 16'd10, 16'd0, 16'd0);
    query_gap(16'd20, 16'd23, 16'd10, 16'd12, 16'd16);
    query_gap(16'd20, 16'd24, 16'd20, 16'd26, 16'd26);
    query_gap(16'd20, 16'd23, 16'd10, 16'd16, 16'd16);
    query_gap(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    drain();

    // random phases over table sizes, every read slot loaded first
    for (p = 0; p < 11; p++) begin
      write_count(sizes[p]);
      n = (sizes[p] > SLOTS) ? SLOTS : sizes[p];
      for (s = 0; s < n; s++)
        if (!ever_loaded[s])
          load_slot(s, 8'($urandom_range(0, 255)), rect_dim(1), rect_dim(0));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        burst_left--;
        if (p == SQUEEZE_PHASE && k == PHASE_ITEMS / 2) squeeze_req = 1'b1;
        random_item(n);
      end
      drain();
    end

    $display("covered %0d loads and %0d queries over 11 table sizes", ledger.loads,
             ledger.queries);
    $display("results: %0d placed, %0d no fit, %0d table exhausted, %0d checked",
             ledger.placed, ledger.misses, ledger.finished, ledger.checked);
    if (ledger.errors == 0 && ledger.due_picks.size() == 0) begin
      $display("skyline_rect_score_select_top_tb: done, clean");
    end else begin
      if (ledger.due_picks.size() != 0)
        ledger.report($sformatf("%0d placements never arrived", ledger.due_picks.size()));
      $display("skyline_rect_score_select_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/srss_pkg.sv
design/srss_score.sv
design/skyline_rect_score_select_top.sv
tb/sv/skyline_rect_score_select_top_tb.sv
